// ===== rtl/core/ascii_hex_crc16_frame_builder_unit_defines.svh =====
// Assertion macros shared by the ASCII hex CRC-16 frame builder RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef ASCII_HEX_CRC16_FRAME_BUILDER_UNIT_DEFINES_SVH
`define ASCII_HEX_CRC16_FRAME_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AHCFB_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("frame builder assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define AHCFB_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("frame builder assertion failed");

`endif

// ===== rtl/core/ahcfb_pkg.sv =====
// Shared types, constants and functions of the ASCII hex CRC-16 frame builder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ahcfb_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;  // 0x8005 bit-reversed
  localparam logic [7:0]  CHAR_COLON    = 8'h3A;
  localparam logic [7:0]  CHAR_EQUAL    = 8'h3D;
  localparam int          QUEUE_DEPTH   = 2;

  // One classified payload byte, handed from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        start;  // first byte of a frame: prefix with a colon
    logic        last;   // final byte: append the CRC and the closing mark
    logic [15:0] crc;    // CRC including this byte
  } job_t;

  // Character sequencer states of the back end.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COLON,
    ST_HI,
    ST_LO,
    ST_CRC0,
    ST_CRC1,
    ST_CRC2,
    ST_CRC3,
    ST_EQUAL
  } step_t;

  // Reflected CRC-16 update over one byte, bit at a time.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  // Upper-case ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

endpackage

// ===== rtl/core/ahcfb_front.sv =====
// Front end of the frame builder: accepts payload beats, runs the CRC and frame state.
// Depends on ahcfb_pkg and the assertion macros header.
`include "ascii_hex_crc16_frame_builder_unit_defines.svh"

module ahcfb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // payload_byte
  input  logic              s_tlast,   // frame_last
  input  logic              q_full,
  output logic              q_push,
  output ahcfb_pkg::job_t   q_job
);

  logic [15:0] crc;
  logic        frame_open;
  logic [15:0] crc_upd;
  logic        accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign crc_upd  = ahcfb_pkg::crc16_byte(crc, s_tdata);

  assign q_push      = accept;
  assign q_job.data  = s_tdata;
  assign q_job.start = !frame_open;
  assign q_job.last  = s_tlast;
  assign q_job.crc   = crc_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= ahcfb_pkg::CRC_INIT;
      frame_open <= 1'b0;
    end else if (accept) begin
      crc        <= s_tlast ? ahcfb_pkg::CRC_INIT : crc_upd;
      frame_open <= !s_tlast;
    end
  end

  `AHCFB_ASSERT_NEXT(a_front_close, clk, rst, accept && s_tlast, (crc == ahcfb_pkg::CRC_INIT) && !frame_open)
  `AHCFB_ASSERT_NEXT(a_front_open, clk, rst, accept && !s_tlast, frame_open)

endmodule

// ===== rtl/core/ahcfb_queue.sv =====
// Short job queue between the front and back ends of the frame builder.
// Depends on ahcfb_pkg and the assertion macros header.
`include "ascii_hex_crc16_frame_builder_unit_defines.svh"

module ahcfb_queue #(
  parameter int DEPTH = ahcfb_pkg::QUEUE_DEPTH  // two or more
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ahcfb_pkg::job_t wr_job,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ahcfb_pkg::job_t rd_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ahcfb_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full   = (count == CNT_W'(DEPTH));
  assign valid  = (count != '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `AHCFB_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `AHCFB_ASSERT_NOW(a_queue_pop_nonempty, clk, rst, pop, valid)

endmodule

// ===== rtl/core/ahcfb_back.sv =====
// Back end of the frame builder: turns queued jobs into ASCII characters, one per beat.
// Depends on ahcfb_pkg and the assertion macros header.
`include "ascii_hex_crc16_frame_builder_unit_defines.svh"

module ahcfb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  ahcfb_pkg::job_t q_job,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // char_code
  output logic            m_tlast,   // run_last
  output logic            m_tuser    // frame_done
);

  ahcfb_pkg::step_t state;
  ahcfb_pkg::step_t state_next;
  ahcfb_pkg::job_t  job;
  logic             emit;
  logic             final_char;
  logic [7:0]       char_sel;
  logic             load_ok;

  assign load_ok = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    final_char = 1'b0;
    char_sel   = ahcfb_pkg::CHAR_COLON;
    unique case (state)
      ahcfb_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_job.start ? ahcfb_pkg::ST_COLON : ahcfb_pkg::ST_HI;
        end
      end
      default: begin
        case (state)
          ahcfb_pkg::ST_COLON: char_sel = ahcfb_pkg::CHAR_COLON;
          ahcfb_pkg::ST_HI:    char_sel = ahcfb_pkg::hex_char(job.data[7:4]);
          ahcfb_pkg::ST_LO:    char_sel = ahcfb_pkg::hex_char(job.data[3:0]);
          ahcfb_pkg::ST_CRC0:  char_sel = ahcfb_pkg::hex_char(job.crc[7:4]);
          ahcfb_pkg::ST_CRC1:  char_sel = ahcfb_pkg::hex_char(job.crc[3:0]);
          ahcfb_pkg::ST_CRC2:  char_sel = ahcfb_pkg::hex_char(job.crc[15:12]);
          ahcfb_pkg::ST_CRC3:  char_sel = ahcfb_pkg::hex_char(job.crc[11:8]);
          default:             char_sel = ahcfb_pkg::CHAR_EQUAL;
        endcase
        final_char = ((state == ahcfb_pkg::ST_LO) && !job.last) ||
                     (state == ahcfb_pkg::ST_EQUAL);
        if (load_ok) begin
          emit = 1'b1;
          if (final_char) begin
            if (q_valid) begin
              q_pop      = 1'b1;
              state_next = q_job.start ? ahcfb_pkg::ST_COLON : ahcfb_pkg::ST_HI;
            end else begin
              state_next = ahcfb_pkg::ST_IDLE;
            end
          end else begin
            unique case (state)
              ahcfb_pkg::ST_COLON: state_next = ahcfb_pkg::ST_HI;
              ahcfb_pkg::ST_HI:    state_next = ahcfb_pkg::ST_LO;
              ahcfb_pkg::ST_LO:    state_next = ahcfb_pkg::ST_CRC0;
              ahcfb_pkg::ST_CRC0:  state_next = ahcfb_pkg::ST_CRC1;
              ahcfb_pkg::ST_CRC1:  state_next = ahcfb_pkg::ST_CRC2;
              ahcfb_pkg::ST_CRC2:  state_next = ahcfb_pkg::ST_CRC3;
              ahcfb_pkg::ST_CRC3:  state_next = ahcfb_pkg::ST_EQUAL;
              default:             state_next = ahcfb_pkg::ST_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ahcfb_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
    if (emit) begin
      m_tdata <= char_sel;
      m_tlast <= final_char;
      m_tuser <= (state == ahcfb_pkg::ST_EQUAL);
    end
  end

  `AHCFB_ASSERT_NOW(a_back_done_is_last, clk, rst, m_tvalid && m_tuser, m_tlast)
  `AHCFB_ASSERT_NOW(a_back_crc_on_last, clk, rst, state == ahcfb_pkg::ST_CRC0, job.last)

endmodule

// ===== rtl/core/ascii_hex_crc16_frame_builder_unit.sv =====
// Top level of the ASCII hex CRC-16 (MODBUS) transmit frame builder.
// Depends on ahcfb_pkg, ahcfb_front, ahcfb_queue, ahcfb_back.

// Each payload beat on the slave side becomes a run of ASCII character beats on
// the master side: a colon before the first byte of a frame, the byte as two
// upper-case hex digits (high nibble first), and, on the byte marked by s_tlast,
// the CRC-16/MODBUS low byte and then high byte as four hex digits and a closing
// equals sign. m_tlast marks the final character of each run and m_tuser marks the
// equals sign that ends a frame. The master side moves one character per cycle
// while m_tready is high and characters are pending: a byte inside a frame gives
// two characters, the first byte of a frame three, and the last byte seven (eight
// for a single-byte frame). The front end computes the CRC in the cycle a beat is
// accepted and hands the byte on through a short queue, so input beats keep
// arriving until the queue is full while earlier characters are still being sent.
// When the back end is idle, an accepted beat is written into the queue, popped
// into the back end's job register, and its first character then goes to m_tdata.

module ascii_hex_crc16_frame_builder_unit #(
  parameter int QUEUE_DEPTH = ahcfb_pkg::QUEUE_DEPTH  // two or more
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] payload_byte
  input  logic       s_tlast,   // frame_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_code
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // [0] frame_done
);

  // Job path from the front end into the queue.
  logic            q_full;
  logic            q_push;
  ahcfb_pkg::job_t q_wr_job;

  // Job path from the queue into the back end.
  logic            q_valid;
  logic            q_pop;
  ahcfb_pkg::job_t q_rd_job;

  ahcfb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_wr_job)
  );

  ahcfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (q_wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .rd_job (q_rd_job)
  );

  // The back end holds its own output register, so a stalled master side only
  // fills the queue and never loses a character.
  ahcfb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (q_rd_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the ASCII hex CRC-16 frame builder: payload beats in,
// predicted character beats checked out. Needs only ahcfb_pkg and the top level.
`timescale 1ns / 1ps

module tb;

  localparam logic [7:0]  ASCII_ZERO    = 8'h30;
  localparam logic [7:0]  ASCII_UPPER_A = 8'h41;
  localparam logic [15:0] MODBUS_SEED   = 16'hFFFF;
  localparam logic [15:0] MODBUS_POLY_R = 16'hA001;  // 0x8005 with its bits reversed
  localparam int          RANDOM_BEATS  = 245;
  localparam int          DRAIN_LIMIT   = 20000;
  localparam int          TAIL_CYCLES   = 16;

  // Sink stall behaviors; the receiver switches between them at random intervals.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  // One character beat as it should appear on the master side.
  typedef struct {
    logic [7:0] code;
    logic       run_end;
    logic       closes;
  } tx_char_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  ascii_hex_crc16_frame_builder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Predictor state: the CRC over the open frame and whether a colon went out yet.
  logic [15:0] crc_accum;
  logic        frame_started;
  tx_char_t    expected_chars[$];

  int error_count;
  int payload_beats;
  int chars_checked;
  int frames_closed;
  int burst_left;

  rx_mode_t rx_mode;
  int       rx_mode_left;
  int       rx_tick;

  always #5 clk = ~clk;

  initial begin
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
  end

  // CRC-16/MODBUS over one byte, shifting the data in LSB first.
  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0] data);
    logic [15:0] c;
    logic        feedback;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      feedback = c[0] ^ data[i];
      c = c >> 1;
      if (feedback) begin
        c = c ^ MODBUS_POLY_R;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ASCII_ZERO + {4'h0, nib};
    end
    return ASCII_UPPER_A + {4'h0, nib} - 8'd10;
  endfunction

  function automatic tx_char_t make_char(input logic [7:0] code, input logic closes);
    tx_char_t ch;
    ch.code    = code;
    ch.run_end = 1'b0;
    ch.closes  = closes;
    return ch;
  endfunction

  // Works out the character run caused by one accepted payload beat and queues it.
  task automatic predict_byte_chars(input logic [7:0] data, input logic frame_end);
    tx_char_t run[$];
    if (!frame_started) begin
      run.push_back(make_char(ahcfb_pkg::CHAR_COLON, 1'b0));
      frame_started = 1'b1;
    end
    crc_accum = crc16_modbus_step(crc_accum, data);
    run.push_back(make_char(nibble_ascii(data[7:4]), 1'b0));
    run.push_back(make_char(nibble_ascii(data[3:0]), 1'b0));
    if (frame_end) begin
      // The CRC goes out low byte first, each byte high nibble first.
      run.push_back(make_char(nibble_ascii(crc_accum[7:4]), 1'b0));
      run.push_back(make_char(nibble_ascii(crc_accum[3:0]), 1'b0));
      run.push_back(make_char(nibble_ascii(crc_accum[15:12]), 1'b0));
      run.push_back(make_char(nibble_ascii(crc_accum[11:8]), 1'b0));
      run.push_back(make_char(ahcfb_pkg::CHAR_EQUAL, 1'b1));
      crc_accum     = MODBUS_SEED;
      frame_started = 1'b0;
    end
    run[run.size() - 1].run_end = 1'b1;
    foreach (run[i]) begin
      expected_chars.push_back(run[i]);
    end
  endtask

  // Sends one payload beat. The source works in bursts; a gap, when one is due,
  // is taken before the beat so that tvalid is only ever lowered between bursts.
  task automatic send_payload(input logic [7:0] data, input logic frame_end);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= frame_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte_chars(data, frame_end);
    payload_beats++;
    burst_left--;
  endtask

  // Receiver stall pattern, independent of the source.
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      rx_mode      <= RX_STREAM;
      rx_mode_left <= 40;
      rx_tick      <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(16, 96);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STREAM:  m_tready <= 1'b1;
        RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
        RX_PATTERN: m_tready <= (rx_tick % 3 != 0);
        default:    m_tready <= 1'b1;
      endcase
    end
  end

  // Compares every accepted character beat with the oldest prediction.
  always @(posedge clk) begin
    tx_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character beat: char_code %h run_last %b frame_done %b",
               m_tdata, m_tlast, m_tuser);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (m_tdata !== want.code) begin
          $error("char_code mismatch: expected %h, got %h", want.code, m_tdata);
          error_count++;
        end
        if (m_tlast !== want.run_end) begin
          $error("run_last mismatch: expected %b, got %b", want.run_end, m_tlast);
          error_count++;
        end
        if (m_tuser !== want.closes) begin
          $error("frame_done mismatch: expected %b, got %b", want.closes, m_tuser);
          error_count++;
        end
        if (want.closes) begin
          frames_closed++;
        end
      end
    end
  end

  // Single-byte frames: colon, data, CRC and the closing mark all from one beat.
  task automatic test_single_byte_frames();
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b1);
    send_payload(8'h5A, 1'b1);
  endtask

  // The standard check string "123456789" must close with CRC 0x4B37.
  task automatic test_check_string();
    for (int i = 1; i <= 9; i++) begin
      send_payload(ASCII_ZERO + 8'(i), i == 9);
    end
  endtask

  // Every hex digit once within one frame: even digits high, odd digits low nibble.
  task automatic test_all_digits();
    logic [7:0] digits[8] = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
    foreach (digits[i]) begin
      send_payload(digits[i], i == 7);
    end
  endtask

  // Random frames: mostly short, now and then a long one, with extreme bytes mixed in.
  task automatic test_random_frames();
    int start_beats;
    int frame_len;
    logic [7:0] data;
    start_beats = payload_beats;
    while (payload_beats - start_beats < RANDOM_BEATS) begin
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int i = 0; i < frame_len; i++) begin
        case ($urandom_range(0, 9))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom);
        endcase
        send_payload(data, i == frame_len - 1);
      end
    end
  endtask

  initial begin
    int waited;
    crc_accum     = MODBUS_SEED;
    frame_started = 1'b0;
    error_count   = 0;
    payload_beats = 0;
    chars_checked = 0;
    frames_closed = 0;
    burst_left    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_byte_frames();
    test_check_string();
    test_all_digits();
    test_random_frames();
    s_tvalid <= 1'b0;

    waited = 0;
    while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d predicted character beats never arrived", expected_chars.size());
      error_count++;
    end

    $display("Sent %0d payload beats in %0d frames; checked %0d character beats,",
             payload_beats, frames_closed, chars_checked);
    $display("with bursty source gaps and four sink stall patterns.");
    if (error_count == 0) begin
      $display("ascii_hex_crc16_frame_builder_unit verification clean");
    end else begin
      $display("ascii_hex_crc16_frame_builder_unit verification failed");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("ascii_hex_crc16_frame_builder_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ahcfb_pkg.sv
rtl/core/ahcfb_front.sv
rtl/core/ahcfb_queue.sv
rtl/core/ahcfb_back.sv
rtl/core/ascii_hex_crc16_frame_builder_unit.sv
bench/tb.sv
